// ===== sv/bwmbc_pkg.sv =====
// Package for the byte/word memory with bounds checking.
// Holds request codes, the request and response word types and the
// controller/datapath command and status structs. No dependencies.
package bwmbc_pkg;

	localparam int DEF_MEM_WORDS = 4096;
	localparam int BYTES_PER_WORD = 8;
	localparam int OFS_W = 3;

	localparam logic [2:0] REQ_WORD_RD = 3'd0;
	localparam logic [2:0] REQ_WORD_WR = 3'd1;
	localparam logic [2:0] REQ_BYTE_RD = 3'd2;
	localparam logic [2:0] REQ_BYTE_WR = 3'd3;
	localparam logic [2:0] REQ_UNAL_RD = 3'd4;
	localparam logic [2:0] REQ_UNAL_WR = 3'd5;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] address;
		logic [63:0] write_data;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic [63:0] read_data;
		logic        mem_error;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rd_hi;
		logic cap_lo;
		logic cap_hi;
		logic wr_lo;
		logic wr_hi;
		logic clr_wr;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic err;
		logic wr;
		logic two;
		logic clr_last;
	} ctl_sts_t;

endpackage

// ===== sv/byte_word_memory_bounds_check.sv =====
// Top level of the byte-addressable memory of 64-bit words with bounds check.
// Joins bwmbc_ctrl and bwmbc_datapath; depends on bwmbc_pkg.
//
//   channel   signals            handshake
//   request   req (req_t)        taken when start is high and busy is low
//   result    rsp (rsp_t)        valid for one cycle while done is high
//
// A request passes through the states S_RD_LO, S_RD_HI, S_CAP_HI and S_DONE
// before its result is strobed; an unaligned write that spans two words adds
// S_WR_HI after S_CAP_HI, and a failed bounds check goes from S_RD_LO straight
// to S_DONE. After reset the memory is cleared one word a cycle, all MEM_WORDS
// words, with busy held high. The result cannot be stalled; a new request
// can be accepted in the same cycle as the strobe.
module byte_word_memory_bounds_check #(
	parameter int MEM_WORDS = bwmbc_pkg::DEF_MEM_WORDS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bwmbc_pkg::req_t req,
	output logic            done,
	output bwmbc_pkg::rsp_t rsp
);
	import bwmbc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	bwmbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bwmbc_datapath #(
		.MEM_WORDS (MEM_WORDS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// ===== sv/bwmbc_datapath.sv =====
// Datapath of the byte/word memory: request registers, bounds check,
// word memory with its clearing counter, byte merge and result register.
// Depends on bwmbc_pkg.
module bwmbc_datapath #(
	parameter int MEM_WORDS = bwmbc_pkg::DEF_MEM_WORDS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bwmbc_pkg::req_t     req,
	input  bwmbc_pkg::ctl_cmd_t cmd,
	output bwmbc_pkg::ctl_sts_t sts,
	output bwmbc_pkg::rsp_t     rsp
);
	import bwmbc_pkg::*;

	localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam logic [32:0] WORD_LIMIT = 33'(MEM_WORDS);
	localparam logic [32:0] BYTE_LIMIT = 33'(MEM_WORDS * BYTES_PER_WORD);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

	logic [63:0] mem [MEM_WORDS];
	logic [63:0] rdata_q;

	logic [2:0]       type_q;
	logic [OFS_W-1:0] ofs_q;
	logic [IDX_W-1:0] idx0_q;
	logic [IDX_W-1:0] idx1_q;
	logic             err_q;
	logic [63:0]      wdata_q;
	logic [7:0]       wbyte_q;
	logic [63:0]      lo_q;
	logic [63:0]      hi_q;
	logic [IDX_W-1:0] clr_q;
	rsp_t             rsp_q;

	logic [32:0]      a33;
	logic [31:0]      word_of_byte;
	logic [IDX_W-1:0] idx0_d;
	logic             err_d;
	logic [127:0]     win;
	logic [127:0]     wwin;
	logic [127:0]     wmask;
	logic [6:0]       sh7;
	logic [5:0]       sh6;
	logic [63:0]      lo_new;
	logic [63:0]      rd_val;
	logic [IDX_W-1:0] rd_addr;
	logic             we;
	logic [IDX_W-1:0] wr_addr;
	logic [63:0]      wr_data;

	always_comb begin
		a33 = {1'b0, req.address};
		word_of_byte = req.address >> OFS_W;
		case (req.req_type)
			REQ_WORD_RD, REQ_WORD_WR: begin
				err_d = (a33 >= WORD_LIMIT);
				idx0_d = req.address[IDX_W-1:0];
			end
			REQ_BYTE_RD, REQ_BYTE_WR: begin
				err_d = (a33 >= BYTE_LIMIT);
				idx0_d = word_of_byte[IDX_W-1:0];
			end
			REQ_UNAL_RD, REQ_UNAL_WR: begin
				err_d = ((a33 + 33'(BYTES_PER_WORD)) > BYTE_LIMIT);
				idx0_d = word_of_byte[IDX_W-1:0];
			end
			default: begin
				err_d = 1'b1;
				idx0_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req.req_type;
			ofs_q <= req.address[OFS_W-1:0];
			idx0_q <= idx0_d;
			idx1_q <= (idx0_d == LAST_IDX) ? idx0_d : idx0_d + IDX_W'(1);
			err_q <= err_d;
			wdata_q <= req.write_data;
			wbyte_q <= req.write_byte;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
		if (cmd.cap_hi) begin
			hi_q <= rdata_q;
		end
		if (cmd.finish) begin
			rsp_q.mem_error <= err_q;
			rsp_q.read_data <= err_q ? 64'd0 : rd_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	always_comb begin
		win = {hi_q, lo_q};
		sh7 = {ofs_q, 3'b000};
		sh6 = {ofs_q, 3'b000};
		wmask = {64'd0, {64{1'b1}}} << sh7;
		wwin = (win & ~wmask) | ({64'd0, wdata_q} << sh7);
		case (type_q)
			REQ_WORD_WR: lo_new = wdata_q;
			REQ_BYTE_WR: lo_new = (lo_q & ~(64'hFF << sh6)) | ({56'd0, wbyte_q} << sh6);
			REQ_UNAL_WR: lo_new = wwin[63:0];
			default:     lo_new = lo_q;
		endcase
		case (type_q)
			REQ_WORD_RD: rd_val = lo_q;
			REQ_BYTE_RD: rd_val = {56'd0, 8'(lo_q >> sh6)};
			REQ_UNAL_RD: rd_val = 64'(win >> sh7);
			default:     rd_val = 64'd0;
		endcase
	end

	always_comb begin
		rd_addr = cmd.rd_hi ? idx1_q : idx0_q;
		we = cmd.clr_wr | cmd.wr_lo | cmd.wr_hi;
		if (cmd.clr_wr) begin
			wr_addr = clr_q;
			wr_data = 64'd0;
		end else if (cmd.wr_lo) begin
			wr_addr = idx0_q;
			wr_data = lo_new;
		end else begin
			wr_addr = idx1_q;
			wr_data = wwin[127:64];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	assign sts.err = err_q;
	assign sts.wr = (type_q == REQ_WORD_WR) || (type_q == REQ_BYTE_WR)
		|| (type_q == REQ_UNAL_WR);
	assign sts.two = (type_q == REQ_UNAL_WR) && (ofs_q != '0);
	assign sts.clr_last = (clr_q == LAST_IDX);
	assign rsp = rsp_q;

endmodule

// ===== sv/bwmbc_ctrl.sv =====
// Controller state machine of the byte/word memory.
// Sequences the clearing pass, the two word reads and the write-back.
// Depends on bwmbc_pkg.
module bwmbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  bwmbc_pkg::ctl_sts_t sts,
	output bwmbc_pkg::ctl_cmd_t cmd
);
	import bwmbc_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_LO,
		S_RD_HI,
		S_CAP_HI,
		S_WR_HI,
		S_DONE
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) state_q <= S_RD_LO;
				end
				S_RD_LO: begin
					state_q <= sts.err ? S_DONE : S_RD_HI;
				end
				S_RD_HI: begin
					state_q <= S_CAP_HI;
				end
				S_CAP_HI: begin
					state_q <= sts.two ? S_WR_HI : S_DONE;
				end
				S_WR_HI: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					done_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLEAR:  cmd.clr_wr = 1'b1;
			S_IDLE:   cmd.load = start;
			S_RD_LO:  cmd.rd_hi = 1'b0;
			S_RD_HI: begin
				cmd.rd_hi = 1'b1;
				cmd.cap_lo = 1'b1;
			end
			S_CAP_HI: begin
				cmd.cap_hi = 1'b1;
				cmd.wr_lo = sts.wr;
			end
			S_WR_HI:  cmd.wr_hi = 1'b1;
			S_DONE:   cmd.finish = 1'b1;
			default:  cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the block busy");
	a_no_bad_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_lo || cmd.wr_hi) |-> (!sts.err && sts.wr))
		else $error("memory write on an erroring or read request");
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> (busy && !cmd.wr_lo && !cmd.wr_hi))
		else $error("clearing write overlaps a request");
`endif

endmodule
